// ===== sv/running_percentile_tracker_core_assert.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef RUNNING_PERCENTILE_TRACKER_CORE_ASSERT_SVH
`define RUNNING_PERCENTILE_TRACKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold on every edge outside reset.
`define RPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition on one edge implies a result on the next edge.
`define RPT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RPT_ASSERT(lbl, clk, rst, prop, msg)
`define RPT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/rpt_pkg.sv =====
package rpt_pkg;

  localparam int unsigned PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd90;
  localparam int unsigned PCT_ROUND = 50;
  localparam int unsigned PCT_DIV   = 100;

  // select tree radix
  localparam int unsigned RADIX_BITS = 4;
  localparam int unsigned RADIX      = 16;

  // per-cell control, driven from the count
  typedef struct packed {
    logic load;      // insert this cycle
    logic occupied;  // cell index below count
    logic tail;      // cell index equals count
  } cell_ctrl_t;

  function automatic int unsigned sel_levels(int unsigned iw);
    return (iw + RADIX_BITS - 1) / RADIX_BITS;
  endfunction

endpackage

// ===== sv/rpt_cell.sv =====
module rpt_cell import rpt_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  cell_ctrl_t   ctrl,
  input  logic [W-1:0] sample,
  input  logic [W-1:0] prev_value,
  input  logic         prev_greater,
  output logic [W-1:0] value,
  output logic         greater
);

  // strict compare: equal samples stay ahead of the new one
  assign greater = ctrl.occupied && ($signed(value) > $signed(sample));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.occupied) begin
        if (prev_greater) begin
          value <= prev_value;
        end else if (greater) begin
          value <= sample;
        end
      end else if (ctrl.tail) begin
        value <= prev_greater ? prev_value : sample;
      end
    end
  end

endmodule

// ===== sv/rpt_select.sv =====
module rpt_select import rpt_pkg::*; #(
  parameter int unsigned N  = 1024,
  parameter int unsigned W  = 32,
  parameter int unsigned IW = 10
) (
  input  logic          clk,
  input  logic [W-1:0]  entries [N],
  input  logic [IW-1:0] rank,
  output logic [W-1:0]  result
);

  localparam int unsigned LEVELS = sel_levels(IW);
  localparam int unsigned DW     = LEVELS * RADIX_BITS;
  localparam int unsigned NP     = 1 << DW;

  function automatic int unsigned level_nodes(int unsigned l);
    return NP >> (RADIX_BITS * l);
  endfunction

  function automatic int unsigned level_off(int unsigned l);
    int unsigned o;
    o = 0;
    for (int unsigned j = 1; j < l; j++) begin
      o = o + level_nodes(j);
    end
    return o;
  endfunction

  localparam int unsigned TOTAL = level_off(LEVELS + 1);

  logic [W-1:0]  leaf [NP];
  logic [W-1:0]  node [TOTAL];
  logic [DW-1:0] rank_pad;

  assign rank_pad = DW'(rank);

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign leaf[j] = entries[j];
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // each radix-16 level is registered, lowest digit first
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < level_nodes(l); j++) begin : g_node
      logic [W-1:0] grp [RADIX];
      for (genvar k = 0; k < RADIX; k++) begin : g_in
        if (l == 1) begin : g_first
          assign grp[k] = leaf[RADIX * j + k];
        end else begin : g_upper
          assign grp[k] = node[level_off(l - 1) + RADIX * j + k];
        end
      end
      always_ff @(posedge clk) begin
        node[level_off(l) + j] <= grp[rank_pad[RADIX_BITS * l - 1 -: RADIX_BITS]];
      end
    end
  end

  assign result = node[TOTAL - 1];

endmodule

// ===== sv/running_percentile_tracker_core.sv =====
// Running percentile tracker, nearest rank.
// Input channel (in_valid/in_ready, sample): one signed Q16.16 request per
// item. The sample is inserted into a sorted row of cells, and the block
// returns the stored sample at rank round(pct*(n-1)/100), halves up.
// Output channel (out_valid/out_ready): percentile_value, samples_held
// (count after the request) and buffer_full (request dropped, store full).
// Config channel (cfg_valid/cfg_ready, percentile): percentile in whole
// percent, values above 100 act as 100. Write only while idle.
// Flow: two multiply stages (S_SCALE, S_RANK) scale the rank, then a
// registered radix-16 select tree of LEVELS = ceil(log2(MAX_SAMPLES)/4)
// levels (3 at 1024 entries) walks it one digit per level in S_SEL, and
// S_OUT raises out_valid; in_ready is low from acceptance until then.
// in_ready is high whenever the core is idle, also while a finished result
// waits in the output register; a stalled receiver holds the next result
// in the core until the output register frees up.
// Reset (rst, synchronous): count 0, percentile 90, no result pending.
// Cell contents are not cleared; only cells below the count are ever read.
`include "running_percentile_tracker_core_assert.svh"

module running_percentile_tracker_core import rpt_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 32,
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [PCT_W-1:0]       percentile,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] percentile_value,
  output logic [CW-1:0]          samples_held,
  output logic                   buffer_full
);

  localparam int unsigned IW     = $clog2(MAX_SAMPLES);
  localparam int unsigned LEVELS = sel_levels(IW);
  localparam int unsigned LW     = $clog2(LEVELS + 1);
  // rank = (pct*(n-1)+50)/100 as multiply by reciprocal, exact for x < 2^XW
  localparam int unsigned XW     = PCT_W + CW + 1;
  localparam int unsigned K      = XW + 7;
  localparam int unsigned RW     = K - 6;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) / 64'd100) + 64'd1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_RANK  = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic [PCT_W-1:0] pct;
  logic             full_flag;
  logic [XW-1:0]    scaled;
  logic [IW-1:0]    rank;
  logic [LW-1:0]    sel_cnt;

  logic                   accept;
  logic                   full_now;
  logic                   load;
  logic [PCT_W-1:0]       pct_eff;
  logic [XW+RW-1:0]       prod;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] sel_value;

  logic [SAMPLE_BITS-1:0] cell_value [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] cell_gt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full_now  = (count == CW'(MAX_SAMPLES));
  assign load      = accept && !full_now;
  assign pct_eff   = (pct > PCT_MAX) ? PCT_MAX : pct;
  assign prod      = (XW+RW)'(scaled) * (XW+RW)'(RECIP);
  assign out_free  = !out_valid || out_ready;

  // Insertion row: each cell but cell 0 reads its left neighbor. Cells past the
  // insert point shift right by one, the first larger cell takes the sample.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    cell_ctrl_t             ctrl;
    logic [SAMPLE_BITS-1:0] pv;
    logic                   pg;

    assign ctrl.load     = load;
    assign ctrl.occupied = (CW'(i) < count);
    assign ctrl.tail     = (CW'(i) == count);

    if (i == 0) begin : g_head
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_body
      assign pv = cell_value[i - 1];
      assign pg = cell_gt[i - 1];
    end

    rpt_cell #(.W(SAMPLE_BITS)) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .sample       (sample),
      .prev_value   (pv),
      .prev_greater (pg),
      .value        (cell_value[i]),
      .greater      (cell_gt[i])
    );
  end

  // rank and cells stay put through S_SEL, so every tree level settles before S_OUT
  rpt_select #(.N(MAX_SAMPLES), .W(SAMPLE_BITS), .IW(IW)) u_select (
    .clk     (clk),
    .entries (cell_value),
    .rank    (rank),
    .result  (sel_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= PCT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pct <= percentile;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sel_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!full_now) begin
              count <= count + 1'b1;
            end
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_RANK;
        end
        S_RANK: begin
          sel_cnt <= '0;
          state   <= S_SEL;
        end
        S_SEL: begin
          sel_cnt <= sel_cnt + 1'b1;
          if (sel_cnt == LW'(LEVELS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      full_flag <= full_now;
    end
    if (state == S_SCALE) begin
      scaled <= XW'(XW'(pct_eff) * XW'(count - 1'b1)) + XW'(PCT_ROUND);
    end
    if (state == S_RANK) begin
      rank <= IW'(prod >> K);
    end
    if (state == S_OUT && out_free) begin
      percentile_value <= sel_value;
      samples_held     <= count;
      buffer_full      <= full_flag;
    end
  end

  `RPT_ASSERT(a_count_max, clk, rst, count <= CW'(MAX_SAMPLES), "count above capacity")
  `RPT_ASSERT_NEXT(a_count_grow, clk, rst, load, count == $past(count) + 1'b1, "count not grown")
  `RPT_ASSERT_NEXT(a_full_hold, clk, rst, accept && full_now, count == $past(count), "full store changed")
  `RPT_ASSERT_NEXT(a_out_wait, clk, rst, state == S_OUT && !out_free, state == S_OUT, "output overrun")

endmodule

// ===== dv/running_percentile_tracker_checker.sv =====
module running_percentile_tracker_checker import rpt_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned SW    = 32,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [PCT_W-1:0] percentile,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [SW-1:0] sample,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [SW-1:0] percentile_value,
  input  logic [CW-1:0] samples_held,
  input  logic          buffer_full,
  output int            fail_count,
  output int            outstanding
);

  typedef struct packed {
    logic [SW-1:0] value;
    logic [CW-1:0] held;
    logic          full;
  } rank_result_t;

  logic signed [SW-1:0] sorted_store [DEPTH];
  int unsigned          store_count;
  logic [PCT_W-1:0]     pct_mirror;
  rank_result_t         rank_q[$];
  rank_result_t         want;
  int                   n_err = 0;

  assign fail_count = n_err;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_err++;
  endtask

  // insert one sample into the mirror store unless it is full, and pick the nearest-rank element
  function automatic rank_result_t insert_and_rank(input logic signed [SW-1:0] s);
    rank_result_t r;
    int unsigned  pos;
    int unsigned  i;
    int unsigned  pct;
    int unsigned  rank;
    r.full = 1'b0;
    if (store_count >= DEPTH) begin
      r.full = 1'b1;
    end else begin
      pos = store_count;
      while (pos > 0 && sorted_store[pos-1] > s) pos--;
      for (i = store_count; i > pos; i--) sorted_store[i] = sorted_store[i-1];
      sorted_store[pos] = s;
      store_count++;
    end
    pct  = 32'((pct_mirror > PCT_MAX) ? PCT_MAX : pct_mirror);
    rank = (pct * (store_count - 1) + PCT_ROUND) / PCT_DIV;
    if (rank >= store_count) rank = store_count - 1;
    r.value = sorted_store[rank];
    r.held  = store_count[CW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rank_q.delete();
      store_count = 0;
      pct_mirror  = PCT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) pct_mirror = percentile;
      // results first, so a stray result never pairs with this edge's request
      if (out_valid && out_ready) begin
        if (rank_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: value %h held %0d full %b",
                                    percentile_value, samples_held, buffer_full));
        end else begin
          want = rank_q.pop_front();
          if (percentile_value !== want.value)
            report_mismatch($sformatf("percentile_value %h, want %h",
                                      percentile_value, want.value));
          if (samples_held !== want.held)
            report_mismatch($sformatf("samples_held %0d, want %0d", samples_held, want.held));
          if (buffer_full !== want.full)
            report_mismatch($sformatf("buffer_full %b, want %b", buffer_full, want.full));
        end
      end
      if (in_valid && in_ready) rank_q.insert(rank_q.size(), insert_and_rank($signed(sample)));
    end
    outstanding <= rank_q.size();
  end

endmodule

// ===== dv/tb_running_percentile_tracker_core.sv =====
module tb_running_percentile_tracker_core import rpt_pkg::*;;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned SW    = 32;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  // cycles with no handshake on any channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_LEN   = 157;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [PCT_W-1:0] percentile;
  logic             in_valid;
  logic             in_ready;
  logic [SW-1:0]    sample;
  logic             out_valid;
  logic             out_ready;
  logic [SW-1:0]    percentile_value;
  logic [CW-1:0]    samples_held;
  logic             buffer_full;

  int   fail_count;
  int   outstanding;
  // random idling on both channels; dropped for the tail of the run
  logic idle_on = 1'b1;

  // running value for ascending/descending bursts of samples
  logic [SW-1:0] run_val;
  logic [SW-1:0] run_step;

  running_percentile_tracker_core #(
    .MAX_SAMPLES(DEPTH),
    .SAMPLE_BITS(SW)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .percentile      (percentile),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .percentile_value(percentile_value),
    .samples_held    (samples_held),
    .buffer_full     (buffer_full)
  );

  running_percentile_tracker_checker #(
    .DEPTH(DEPTH),
    .SW   (SW)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .percentile      (percentile),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .percentile_value(percentile_value),
    .samples_held    (samples_held),
    .buffer_full     (buffer_full),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: ready drops in random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hang detector: any handshake on any channel resets the quiet count.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // One sample request. Called at a clock edge; returns at the accepting edge
  // with in_valid still high, so a following request can go back to back.
  task automatic send_sample(input logic [SW-1:0] v);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain: drop in_valid, wait for every pending result, then let the
  // pipeline settle past its latency.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  // Percentile write, only ever issued with the core drained.
  task automatic write_pct(input logic [PCT_W-1:0] v);
    wait_drained();
    cfg_valid  <= 1'b1;
    percentile <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random requests: full-range noise, plus tight clusters that force
  // duplicates, the signed extremes, small Q16.16 values, and monotone runs
  // that stress insertion at either end of the sorted row.
  task automatic random_phase(input int unsigned count);
    logic [SW-1:0] v;
    int            mode;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2, 3: begin
          v = $urandom;
        end
        4, 5: begin
          v = $urandom_range(0, 16) - 8;
        end
        6: begin
          case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0000_0000;
            default: v = 32'hffff_ffff;
          endcase
        end
        7, 8: begin
          if ($urandom_range(0, 15) == 0) begin
            run_val  = $urandom;
            run_step = $urandom_range(0, 1024) - 512;
          end
          run_val = run_val + run_step;
          v = run_val;
        end
        default: begin
          // Q16.16 within about +/-100.0
          v = $urandom_range(0, 32'h00c8_0000) - 32'h0064_0000;
        end
      endcase
      send_sample(v);
    end
  endtask

  initial begin
    logic [SW-1:0]    dir_low [8];
    logic [SW-1:0]    dir_high[6];
    logic [SW-1:0]    dir_sat [5];
    logic [SW-1:0]    dir_mid [5];
    logic [PCT_W-1:0] pct_plan[12];

    rst        = 1'b1;
    cfg_valid  = 1'b0;
    percentile = '0;
    in_valid   = 1'b0;
    sample     = '0;
    run_val    = 32'h0;
    run_step   = 32'h1;

    // signed extremes, repeats of the extremes, and sign neighbors
    dir_low  = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
    dir_high = '{32'hffff_0000, 32'h1234_5678, 32'h7fff_fffe, 32'h8000_0001,
                 32'h0000_0000, 32'h0000_0000};
    dir_sat  = '{32'hedcb_a988, 32'h7fff_ffff, 32'h0000_0002, 32'h8000_0000,
                 32'h4000_0000};
    dir_mid  = '{32'hc000_0000, 32'h0000_8000, 32'hffff_8000, 32'h0000_8000,
                 32'h5555_aaaa};
    // 0 and 127 put every register bit at both values; 127 saturates to 100
    pct_plan = '{7'd50, 7'd90, 7'd1, 7'd99, 7'($urandom_range(0, 127)), 7'd0,
                 7'd100, 7'd127, 7'd95, 7'($urandom_range(0, 127)), 7'd33, 7'd90};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: lowest rank, highest rank, saturated rank, 95th.
    write_pct(7'd0);
    foreach (dir_low[i]) send_sample(dir_low[i]);
    write_pct(PCT_MAX);
    foreach (dir_high[i]) send_sample(dir_high[i]);
    write_pct(7'd127);
    foreach (dir_sat[i]) send_sample(dir_sat[i]);
    write_pct(7'd95);
    foreach (dir_mid[i]) send_sample(dir_mid[i]);

    // Random part. The store fills partway through, after which every
    // request is dropped with buffer_full set and the rank still moves
    // with each new percentile setting.
    foreach (pct_plan[p]) begin
      write_pct(pct_plan[p]);
      if (p == 10) idle_on <= 1'b0;
      random_phase(PHASE_LEN);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
